FILE: hdl/tksl_pkg.sv
// Shared constants, codes and types of the top-k score leaderboard.
package tksl_pkg;

  localparam int CAPACITY   = 64;
  localparam int MAX_PAGE   = 64;
  localparam int ID_W       = 32;
  localparam int SCORE_W    = 32;
  localparam int PAGE_NUM_W = 16;
  localparam int PAGE_W     = 7;
  localparam int RANK_W     = 7;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int SFX_LVL    = $clog2(CAPACITY);
  localparam int WIDE_W     = PAGE_NUM_W + PAGE_W;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  typedef enum logic [1:0] {
    OP_UPLOAD = 2'd0,
    OP_QUERY  = 2'd1,
    OP_PAGE   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_QUERY,
    ST_PCHK,
    ST_PERR,
    ST_SKIP,
    ST_PAGE
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic rd_shift;
  } cell_ctl_t;

endpackage

FILE: hdl/tksl_cell.sv
// One board position: stored entry, compare flags and a read-out shift stage.
module tksl_cell import tksl_pkg::*; (
  input  logic                      clk,
  input  cell_ctl_t                 ctl,
  input  logic                      valid,
  input  logic                      in_range,
  input  logic signed [ID_W-1:0]    cmp_id,
  input  logic signed [SCORE_W-1:0] cmp_score,
  input  logic signed [ID_W-1:0]    new_id,
  input  logic signed [SCORE_W-1:0] new_score,
  input  logic signed [ID_W-1:0]    prev_id,
  input  logic signed [SCORE_W-1:0] prev_score,
  input  logic                      prev_ge,
  input  logic signed [ID_W-1:0]    next_rd_id,
  input  logic signed [SCORE_W-1:0] next_rd_score,
  input  logic                      next_rd_hit,
  output logic signed [ID_W-1:0]    id,
  output logic signed [SCORE_W-1:0] score,
  output logic                      ge,
  output logic                      match,
  output logic signed [ID_W-1:0]    rd_id,
  output logic signed [SCORE_W-1:0] rd_score,
  output logic                      rd_hit
);

  logic id_hit;

  assign id_hit = valid && (id == cmp_id);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      match <= id_hit;
      ge    <= valid && (score >= cmp_score);
    end
    if (ctl.commit && in_range && !ge) begin
      if (prev_ge) begin
        id    <= new_id;
        score <= new_score;
      end else begin
        id    <= prev_id;
        score <= prev_score;
      end
    end
    if (ctl.capture) begin
      rd_id    <= id;
      rd_score <= score;
      rd_hit   <= id_hit;
    end else if (ctl.rd_shift) begin
      rd_id    <= next_rd_id;
      rd_score <= next_rd_score;
      rd_hit   <= next_rd_hit;
    end
  end

endmodule

FILE: hdl/top_k_score_leaderboard.sv
// Top level of the top-k score leaderboard: cell row, control and result register.
//
//   channel  | signals                                        | handshake
//   ---------+------------------------------------------------+---------------------
//   item     | op, user_id, score, page_number, page_size     | item_valid/item_stall
//   result   | status, entry_id, entry_score, entry_rank, last | result_valid/result_stall
//
// An upload compares in every cell at acceptance, then shifts the row once in ST_SHIFT.
// A query shifts the read-out row until the hit reaches cell 0 or the entries run out.
// A page read is checked; a bad one misses, else the row shifts to the page and returns it.
// Reset clears the entry count and all control state; the row needs no clearing.
// The result register holds a stalled item, and an idle block accepts a new item meanwhile.
module top_k_score_leaderboard import tksl_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [1:0]                   op,
  input  logic signed [ID_W-1:0]       user_id,
  input  logic signed [SCORE_W-1:0]    score,
  input  logic [PAGE_NUM_W-1:0]        page_number,
  input  logic [PAGE_W-1:0]            page_size,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         status,
  output logic signed [ID_W-1:0]       entry_id,
  output logic signed [SCORE_W-1:0]    entry_score,
  output logic [RANK_W-1:0]            entry_rank,
  output logic                         last
);

  state_t state, state_next;
  logic [CNT_W-1:0] count, pos, start;
  logic [PAGE_W-1:0] rem;
  logic signed [ID_W-1:0] lat_id;
  logic signed [SCORE_W-1:0] lat_score;
  logic [PAGE_NUM_W-1:0] lat_page;
  logic [PAGE_W-1:0] lat_size;

  logic item_accept, out_free, out_load;
  logic status_next, last_next;
  logic signed [ID_W-1:0] entry_id_next;
  logic signed [SCORE_W-1:0] entry_score_next;
  logic [RANK_W-1:0] entry_rank_next;
  logic pos_inc, count_inc, found, full, ignore, q_done, hit0;
  cell_ctl_t ctl;

  logic [CAPACITY-1:0] match_v, ge_v, valid_v, le_cnt, in_range, rd_hit_a, prev_ge_a, next_hit_a;
  logic [CAPACITY-1:0] sfx [SFX_LVL+1];
  logic signed [ID_W-1:0] cell_id [CAPACITY];
  logic signed [SCORE_W-1:0] cell_score [CAPACITY];
  logic signed [ID_W-1:0] rd_id_a [CAPACITY];
  logic signed [SCORE_W-1:0] rd_score_a [CAPACITY];
  logic signed [ID_W-1:0] prev_id_a [CAPACITY];
  logic signed [SCORE_W-1:0] prev_score_a [CAPACITY];
  logic signed [ID_W-1:0] next_id_a [CAPACITY];
  logic signed [SCORE_W-1:0] next_score_a [CAPACITY];

  logic [PAGE_W-1:0] size_sat, take;
  logic [WIDE_W-1:0] start_wide;
  logic [CNT_W-1:0] avail;
  logic page_bad;

  assign item_stall  = (state != ST_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign out_free    = !result_valid || !result_stall;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign valid_v[i] = CNT_W'(i) < count;
    assign le_cnt[i]  = CNT_W'(i) <= count;
    if (i == 0) begin : g_head
      assign prev_id_a[i]    = '0;
      assign prev_score_a[i] = '0;
      assign prev_ge_a[i]    = 1'b1;
    end else begin : g_body
      assign prev_id_a[i]    = cell_id[i-1];
      assign prev_score_a[i] = cell_score[i-1];
      assign prev_ge_a[i]    = ge_v[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_id_a[i]    = '0;
      assign next_score_a[i] = '0;
      assign next_hit_a[i]   = 1'b0;
    end else begin : g_link
      assign next_id_a[i]    = rd_id_a[i+1];
      assign next_score_a[i] = rd_score_a[i+1];
      assign next_hit_a[i]   = rd_hit_a[i+1];
    end
    tksl_cell u_cell (
      .clk           (clk),
      .ctl           (ctl),
      .valid         (valid_v[i]),
      .in_range      (in_range[i]),
      .cmp_id        (user_id),
      .cmp_score     (score),
      .new_id        (lat_id),
      .new_score     (lat_score),
      .prev_id       (prev_id_a[i]),
      .prev_score    (prev_score_a[i]),
      .prev_ge       (prev_ge_a[i]),
      .next_rd_id    (next_id_a[i]),
      .next_rd_score (next_score_a[i]),
      .next_rd_hit   (next_hit_a[i]),
      .id            (cell_id[i]),
      .score         (cell_score[i]),
      .ge            (ge_v[i]),
      .match         (match_v[i]),
      .rd_id         (rd_id_a[i]),
      .rd_score      (rd_score_a[i]),
      .rd_hit        (rd_hit_a[i])
    );
  end

  // A cell lies at or above the matched entry when any match sits at its index or below it.
  always_comb begin
    sfx[0] = match_v;
    for (int k = 0; k < SFX_LVL; k++) begin
      sfx[k+1] = sfx[k] | (sfx[k] >> (1 << k));
    end
  end

  assign found     = |match_v;
  assign full      = (count == CNT_W'(CAPACITY));
  assign in_range  = found ? sfx[SFX_LVL] : (full ? '1 : le_cnt);
  assign ignore    = (full && ge_v[CAPACITY-1]) || (found && |(match_v & ge_v));
  assign count_inc = (state == ST_SHIFT) && !ignore && !found && !full;

  assign hit0   = rd_hit_a[0];
  assign q_done = hit0 || (({1'b0, pos} + (CNT_W+1)'(1)) >= {1'b0, count});

  assign size_sat   = (page_size > PAGE_W'(MAX_PAGE)) ? PAGE_W'(MAX_PAGE) : page_size;
  assign start_wide = WIDE_W'(lat_page - PAGE_NUM_W'(1)) * WIDE_W'(lat_size);
  assign page_bad   = (lat_page == '0) || (lat_size == '0) || (start_wide >= WIDE_W'(count));
  assign avail      = count - CNT_W'(start_wide);
  assign take       = (WIDE_W'(avail) > WIDE_W'(lat_size)) ? lat_size : PAGE_W'(avail);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_accept) begin
          case (op)
            OP_UPLOAD: state_next = ST_SHIFT;
            OP_QUERY:  state_next = ST_QUERY;
            OP_PAGE:   state_next = ST_PCHK;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_SHIFT: state_next = ST_IDLE;
      ST_QUERY: begin
        if (q_done && out_free) state_next = ST_IDLE;
      end
      ST_PCHK:  state_next = page_bad ? ST_PERR : ST_SKIP;
      ST_PERR: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_SKIP: begin
        if (pos == start) state_next = ST_PAGE;
      end
      ST_PAGE: begin
        if (out_free && rem == PAGE_W'(1)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.capture      = item_accept;
    ctl.commit       = (state == ST_SHIFT) && !ignore;
    ctl.rd_shift     = 1'b0;
    pos_inc          = 1'b0;
    out_load         = 1'b0;
    status_next      = STATUS_OK;
    entry_id_next    = rd_id_a[0];
    entry_score_next = rd_score_a[0];
    entry_rank_next  = RANK_W'(pos + CNT_W'(1));
    last_next        = 1'b1;
    unique case (state)
      ST_QUERY: begin
        if (!q_done) begin
          ctl.rd_shift = 1'b1;
          pos_inc      = 1'b1;
        end else begin
          out_load = out_free;
          if (!hit0) begin
            status_next      = STATUS_MISS;
            entry_id_next    = lat_id;
            entry_score_next = '0;
            entry_rank_next  = '0;
          end
        end
      end
      ST_PERR: begin
        out_load         = out_free;
        status_next      = STATUS_MISS;
        entry_id_next    = '0;
        entry_score_next = '0;
        entry_rank_next  = '0;
      end
      ST_SKIP: begin
        if (pos != start) begin
          ctl.rd_shift = 1'b1;
          pos_inc      = 1'b1;
        end
      end
      ST_PAGE: begin
        last_next = (rem == PAGE_W'(1));
        if (out_free) begin
          out_load     = 1'b1;
          ctl.rd_shift = 1'b1;
          pos_inc      = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      pos          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (count_inc) count <= count + CNT_W'(1);
      if (item_accept) begin
        pos <= '0;
      end else if (pos_inc) begin
        pos <= pos + CNT_W'(1);
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      lat_id    <= user_id;
      lat_score <= score;
      lat_page  <= page_number;
      lat_size  <= size_sat;
    end
    if (state == ST_PCHK) begin
      start <= CNT_W'(start_wide);
      rem   <= take;
    end else if (state == ST_PAGE && out_free) begin
      rem <= rem - PAGE_W'(1);
    end
    if (out_load) begin
      status      <= status_next;
      entry_id    <= entry_id_next;
      entry_score <= entry_score_next;
      entry_rank  <= entry_rank_next;
      last        <= last_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("Entry count exceeds the board capacity.");

  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    state == ST_SHIFT |-> $onehot0(match_v))
    else $error("An id matches more than one board entry.");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    state != ST_SHIFT |=> count == $past(count))
    else $error("Entry count changed outside an upload shift.");

  a_page_rem: assert property (@(posedge clk) disable iff (rst)
    state == ST_PAGE |-> rem != '0)
    else $error("Page emission running with no entries left.");

  a_query_pos: assert property (@(posedge clk) disable iff (rst)
    state == ST_QUERY |-> (pos < count) || (pos == '0))
    else $error("Query scan ran past the occupied entries.");

endmodule
